@@ hdl/atrlf_pkg.sv @@
// shared types and constants for the at response line framer
// result kinds, response classes, framing characters and match texts
// no dependencies
package atrlf_pkg;

	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_DISCARD = 2'd2,
		KIND_TIMEOUT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		RESP_DATA  = 2'd0,
		RESP_OK    = 2'd1,
		RESP_ERROR = 2'd2
	} resp_t;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// register index as decoded from paddr[2]
	typedef enum logic {
		REG_CAPACITY = 1'b0,
		REG_TIMEOUT  = 1'b1
	} reg_idx_t;

	localparam int ADDR_W = 3;
	localparam int CFG_W = 32;

	localparam logic [31:0] CAP_RESET = 32'd63;
	localparam logic [31:0] TMO_RESET = 32'd300;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam int OK_LEN = 2;
	localparam int ERR_LEN = 5;
	localparam int CME_LEN = 12;
	localparam logic [3:0] CME_START = 4'd12;

	localparam logic [7:0] OK_TEXT [0:OK_LEN-1] = '{8'h4F, 8'h4B};
	localparam logic [7:0] ERR_TEXT [0:ERR_LEN-1] = '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};
	localparam logic [7:0] CME_TEXT [0:CME_LEN-1] = '{
		8'h2B, 8'h43, 8'h4D, 8'h45, 8'h20, 8'h45,
		8'h52, 8'h52, 8'h4F, 8'h52, 8'h3A, 8'h20
	};

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		resp_t      rtype;
		logic [7:0] pbyte;
		logic [3:0] start;
	} atrlf_res_t;

endpackage

@@ hdl/atrlf_cfg_regs.sv @@
// apb configuration registers: payload capacity and timeout ticks
// uses atrlf_pkg
module atrlf_cfg_regs import atrlf_pkg::*; #(
	parameter int LENGTH_BITS = 10,
	parameter int TIMER_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [CFG_W-1:0]       pwdata,
	output logic [CFG_W-1:0]       prdata,
	output logic                   pready,
	output logic [LENGTH_BITS-1:0] capacity,
	output logic [TIMER_BITS-1:0]  timeout
);

	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity <= LENGTH_BITS'(CAP_RESET);
			timeout <= TIMER_BITS'(TMO_RESET);
		end else if (wr_en) begin
			unique case (idx)
				REG_CAPACITY: capacity <= pwdata[LENGTH_BITS-1:0];
				REG_TIMEOUT: timeout <= pwdata[TIMER_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CAPACITY: prdata = CFG_W'(capacity);
			REG_TIMEOUT: prdata = CFG_W'(timeout);
			default: prdata = '0;
		endcase
	end

endmodule

@@ hdl/atrlf_framer.sv @@
// line framer state, prefix matchers and idle timer with the per-item step logic
// uses atrlf_pkg; result goes out combinationally for the output register
module atrlf_framer import atrlf_pkg::*; #(
	parameter int LENGTH_BITS = 10,
	parameter int TIMER_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  op_t                    opcode,
	input  logic [7:0]             rx_byte,
	input  logic [LENGTH_BITS-1:0] capacity,
	input  logic [TIMER_BITS-1:0]  timeout,
	output atrlf_res_t             res,
	output logic [LENGTH_BITS-1:0] res_index,
	output logic [LENGTH_BITS-1:0] res_length
);

	typedef enum logic [1:0] {
		ST_WAIT_CR = 2'd0,
		ST_WAIT_LF = 2'd1,
		ST_PAYLOAD = 2'd2,
		ST_STOP_LF = 2'd3
	} state_t;

	state_t                 state_q, state_d;
	logic [LENGTH_BITS-1:0] count_q, count_d;
	logic [TIMER_BITS-1:0]  idle_q, idle_d, idle_inc;
	logic                   ok_q, ok_d, err_q, err_d, cme_q, cme_d;
	logic [2:0]             err_idx;
	logic [3:0]             cme_idx;
	logic                   ok_hit, err_hit, cme_hit;

	assign idle_inc = (idle_q != '1) ? idle_q + 1'b1 : idle_q;
	assign err_idx = (count_q < LENGTH_BITS'(ERR_LEN)) ? count_q[2:0] : 3'd0;
	assign cme_idx = (count_q < LENGTH_BITS'(CME_LEN)) ? count_q[3:0] : 4'd0;
	assign ok_hit = (count_q < LENGTH_BITS'(OK_LEN)) && (rx_byte == OK_TEXT[count_q[0]]);
	assign err_hit = (count_q < LENGTH_BITS'(ERR_LEN)) && (rx_byte == ERR_TEXT[err_idx]);
	assign cme_hit = (rx_byte == CME_TEXT[cme_idx]);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		idle_d = idle_q;
		ok_d = ok_q;
		err_d = err_q;
		cme_d = cme_q;
		res = '{valid: 1'b0, kind: KIND_BYTE, rtype: RESP_DATA, pbyte: 8'd0, start: 4'd0};
		res_index = '0;
		res_length = '0;
		if (opcode == OP_TICK) begin
			idle_d = idle_inc;
			if (idle_inc >= timeout) begin
				idle_d = '0;
				state_d = ST_WAIT_CR;
				count_d = '0;
				{ok_d, err_d, cme_d} = 3'b111;
				res.valid = 1'b1;
				res.kind = KIND_TIMEOUT;
			end
		end else begin
			unique case (state_q)
				ST_WAIT_CR: begin
					if (rx_byte == CH_CR) begin
						state_d = ST_WAIT_LF;
						idle_d = '0;
					end
				end
				ST_WAIT_LF: begin
					if (rx_byte == CH_LF) begin
						state_d = ST_PAYLOAD;
						count_d = '0;
						{ok_d, err_d, cme_d} = 3'b111;
						idle_d = '0;
					end else if (rx_byte != CH_CR) begin
						state_d = ST_WAIT_CR;
						count_d = '0;
						{ok_d, err_d, cme_d} = 3'b111;
						res.valid = 1'b1;
						res.kind = KIND_DISCARD;
					end
				end
				ST_PAYLOAD: begin
					if (rx_byte == CH_CR) begin
						state_d = ST_STOP_LF;
						idle_d = '0;
					end else if (count_q >= capacity) begin
						state_d = ST_WAIT_CR;
						count_d = '0;
						{ok_d, err_d, cme_d} = 3'b111;
						res.valid = 1'b1;
						res.kind = KIND_DISCARD;
					end else begin
						ok_d = ok_q & ok_hit;
						err_d = err_q & err_hit;
						if (count_q < LENGTH_BITS'(CME_LEN))
							cme_d = cme_q & cme_hit;
						count_d = count_q + 1'b1;
						idle_d = '0;
						res.valid = 1'b1;
						res.kind = KIND_BYTE;
						res.pbyte = rx_byte;
						res_index = count_q;
					end
				end
				ST_STOP_LF: begin
					state_d = ST_WAIT_CR;
					count_d = '0;
					{ok_d, err_d, cme_d} = 3'b111;
					res.valid = 1'b1;
					if (rx_byte != CH_LF) begin
						res.kind = KIND_DISCARD;
					end else begin
						idle_d = '0;
						res.kind = KIND_DONE;
						res_length = count_q;
						priority if (ok_q && count_q == LENGTH_BITS'(OK_LEN)) begin
							res.rtype = RESP_OK;
						end else if (err_q && count_q == LENGTH_BITS'(ERR_LEN)) begin
							res.rtype = RESP_ERROR;
						end else if (cme_q && count_q >= LENGTH_BITS'(CME_LEN)) begin
							res.rtype = RESP_ERROR;
							res.start = CME_START;
							res_length = count_q - LENGTH_BITS'(CME_LEN);
						end else begin
							res.rtype = RESP_DATA;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WAIT_CR;
			count_q <= '0;
			idle_q <= '0;
			ok_q <= 1'b1;
			err_q <= 1'b1;
			cme_q <= 1'b1;
		end else if (step) begin
			state_q <= state_d;
			count_q <= count_d;
			idle_q <= idle_d;
			ok_q <= ok_d;
			err_q <= err_d;
			cme_q <= cme_d;
		end
	end

	// before a line's payload begins the counter and matchers sit at restart values
	a_restart_values: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT_CR || state_q == ST_WAIT_LF) |->
		(count_q == '0 && ok_q && err_q && cme_q))
		else $error("framer not restarted outside a line");

	a_timeout_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.valid && res.kind == KIND_TIMEOUT) |-> (opcode == OP_TICK))
		else $error("timeout result from a byte transaction");

	a_payload_clears_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.valid && res.kind == KIND_BYTE) |=>
		(idle_q == '0 && count_q == $past(count_q) + 1'b1))
		else $error("payload byte did not advance count or clear idle timer");

	a_cme_start: assert property (@(posedge clk) disable iff (!arst_n)
		(res.start != 4'd0) |-> (res.kind == KIND_DONE && res.rtype == RESP_ERROR))
		else $error("payload start set on a non error result");

endmodule

@@ hdl/at_response_line_framer_core.sv @@
// top level of the at response line framer: input register, framer, output register
// uses atrlf_pkg, atrlf_cfg_regs, atrlf_framer
//
// channel   direction  handshake          content
// s_*       in         s_tvalid/s_tready  tuser opcode, tdata rx_byte
// m_*       out        m_tvalid/m_tready  tuser kind, response_type; tdata payload fields
// apb       in/out     psel/penable       payload_capacity at 0x0, timeout_ticks at 0x4
//
// one transaction per cycle unless m_tready stalls: each item is held in the input register and
// is stepped through the framer into the output register, zero or one result per item
// a result enters the output register when its item is stepped out of the input register
// the output register refills in the cycle it is taken, so stalls on m_tready back up
// through s_tready without losing or repeating items
// reset puts the framer in wait for carriage return with registers at 63 and 300
module at_response_line_framer_core import atrlf_pkg::*; #(
	parameter int LENGTH_BITS = 10,
	parameter int TIMER_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // rx_byte
	input  logic [0:0]        s_tuser,   // opcode
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [((12 + 2 * LENGTH_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// payload_byte, byte_index, response_length, payload_start, zero fill
	output logic [3:0]        m_tuser,   // kind, response_type
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [CFG_W-1:0]  pwdata,
	output logic [CFG_W-1:0]  prdata,
	output logic              pready
);

	localparam int DATA_W = ((12 + 2 * LENGTH_BITS + 7) / 8) * 8;

	logic [LENGTH_BITS-1:0] capacity;
	logic [TIMER_BITS-1:0]  timeout;

	logic                   valid_s1;
	op_t                    op_s1;
	logic [7:0]             byte_s1;
	logic                   adv;

	atrlf_res_t             res;
	logic [LENGTH_BITS-1:0] res_index, res_length;

	logic                   valid_s2;
	kind_t                  kind_s2;
	resp_t                  rtype_s2;
	logic [7:0]             pbyte_s2;
	logic [LENGTH_BITS-1:0] index_s2, length_s2;
	logic [3:0]             start_s2;

	atrlf_cfg_regs #(
		.LENGTH_BITS(LENGTH_BITS),
		.TIMER_BITS (TIMER_BITS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.capacity(capacity),
		.timeout (timeout)
	);

	assign adv = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= op_t'(s_tuser[0]);
			byte_s1 <= s_tdata;
		end
	end

	atrlf_framer #(
		.LENGTH_BITS(LENGTH_BITS),
		.TIMER_BITS (TIMER_BITS)
	) u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.opcode    (op_s1),
		.rx_byte   (byte_s1),
		.capacity  (capacity),
		.timeout   (timeout),
		.res       (res),
		.res_index (res_index),
		.res_length(res_length)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= res.valid;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			kind_s2 <= res.kind;
			rtype_s2 <= res.rtype;
			pbyte_s2 <= res.pbyte;
			index_s2 <= res_index;
			length_s2 <= res_length;
			start_s2 <= res.start;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser = {rtype_s2, kind_s2};
	assign m_tdata = DATA_W'({start_s2, length_s2, index_s2, pbyte_s2});

endmodule

@@ bench/tb_at_response_line_framer_core.sv @@
// self-checking testbench for at_response_line_framer_core: directed table, then random phases
// uses atrlf_pkg and the rtl under hdl; apb register writes with read-back, stream traffic
// on both sides with random gaps, results checked against the table or a built-in framer predictor
`timescale 1ns / 100ps

module tb_at_response_line_framer_core;
	import atrlf_pkg::*;

	localparam int LEN_W = 10;
	localparam int TMR_W = 24;
	localparam int CYCLE_LIMIT = 2000000;

	typedef enum logic [1:0] {
		FR_WAIT_CR = 2'd0,
		FR_WAIT_LF = 2'd1,
		FR_PAYLOAD = 2'd2,
		FR_STOP_LF = 2'd3
	} fr_state_t;

	typedef struct packed {
		kind_t            kind;
		resp_t            rtype;
		logic [7:0]       pbyte;
		logic [LEN_W-1:0] idx;
		logic [LEN_W-1:0] len;
		logic [3:0]       start;
	} line_res_t;

	typedef struct packed {
		bit         cfg;
		reg_idx_t   creg;
		logic [23:0] cval;
		op_t        op;
		logic [7:0] data;
		bit         typed;
		bit         has_res;
		line_res_t  res;
	} dir_row_t;

	localparam line_res_t NONE = '0;
	localparam line_res_t RES_DISC = '{KIND_DISCARD, RESP_DATA, 8'h00, 10'd0, 10'd0, 4'd0};

	localparam dir_row_t DIRECTED [0:28] = '{
		'{1'b0, REG_CAPACITY, 24'd0, OP_TICK, 8'h5A, 1'b1, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, 8'h00, 1'b1, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, 8'hFF, 1'b1, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, CH_CR, 1'b1, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, CH_CR, 1'b1, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, 8'h41, 1'b1, 1'b1, RES_DISC},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, CH_CR, 1'b1, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, CH_LF, 1'b1, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, 8'h4F, 1'b1, 1'b1,
			'{KIND_BYTE, RESP_DATA, 8'h4F, 10'd0, 10'd0, 4'd0}},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, 8'h4B, 1'b1, 1'b1,
			'{KIND_BYTE, RESP_DATA, 8'h4B, 10'd1, 10'd0, 4'd0}},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, CH_CR, 1'b1, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, CH_LF, 1'b1, 1'b1,
			'{KIND_DONE, RESP_OK, 8'h00, 10'd0, 10'd2, 4'd0}},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, CH_CR, 1'b1, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, CH_LF, 1'b1, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, 8'h00, 1'b1, 1'b1,
			'{KIND_BYTE, RESP_DATA, 8'h00, 10'd0, 10'd0, 4'd0}},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, 8'hFF, 1'b1, 1'b1,
			'{KIND_BYTE, RESP_DATA, 8'hFF, 10'd1, 10'd0, 4'd0}},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, CH_CR, 1'b1, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, 8'h58, 1'b1, 1'b1, RES_DISC},
		'{1'b1, REG_TIMEOUT, 24'd1, OP_BYTE, 8'h00, 1'b0, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_TICK, 8'hA5, 1'b1, 1'b1,
			'{KIND_TIMEOUT, RESP_DATA, 8'h00, 10'd0, 10'd0, 4'd0}},
		'{1'b1, REG_CAPACITY, 24'd1, OP_BYTE, 8'h00, 1'b0, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, CH_CR, 1'b1, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, CH_LF, 1'b1, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, 8'h45, 1'b0, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, 8'h52, 1'b1, 1'b1, RES_DISC},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, CH_CR, 1'b1, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, CH_LF, 1'b1, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, CH_CR, 1'b1, 1'b0, NONE},
		'{1'b0, REG_CAPACITY, 24'd0, OP_BYTE, CH_LF, 1'b1, 1'b1,
			'{KIND_DONE, RESP_DATA, 8'h00, 10'd0, 10'd0, 4'd0}}
	};

	localparam logic [9:0]  PHASE_CAP [0:7] = '{10'd63, 10'd1023, 10'd1, 10'd12,
		10'd5, 10'd200, 10'd40, 10'd16};
	localparam logic [23:0] PHASE_TMO [0:7] = '{24'd300, 24'd16777215, 24'd1, 24'd5,
		24'd20, 24'd2, 24'd40, 24'd7};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;
	logic [0:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [31:0]       m_tdata;
	logic [3:0]        m_tuser;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [CFG_W-1:0]  pwdata;
	logic [CFG_W-1:0]  prdata;
	logic              pready;

	// framer predictor state
	fr_state_t        fstate;
	logic [LEN_W-1:0] line_len;
	logic [TMR_W-1:0] idle_ticks;
	bit               ok_live;
	bit               err_live;
	bit               cme_live;
	logic [LEN_W-1:0] cap_limit;
	logic [TMR_W-1:0] tmo_limit;

	line_res_t pending_results[$];
	int        mismatches = 0;
	int        cycles = 0;
	int        phase_items;
	bit        calm = 1'b0;
	int        rdy_hold = 0;
	int        rdy_pick;

	at_response_line_framer_core #(
		.LENGTH_BITS(LEN_W),
		.TIMER_BITS(TMR_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_at_response_line_framer_core failed");
			$finish;
		end
	end

	task automatic note_mismatch(input string msg);
		if (mismatches < 50)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic void restart_line();
		fstate = FR_WAIT_CR;
		line_len = '0;
		ok_live = 1'b1;
		err_live = 1'b1;
		cme_live = 1'b1;
	endfunction

	function automatic bit frame_predict(input op_t op, input logic [7:0] b,
			output line_res_t r);
		r = '0;
		if (op == OP_TICK) begin
			if (idle_ticks != '1)
				idle_ticks++;
			if (idle_ticks >= tmo_limit) begin
				idle_ticks = '0;
				restart_line();
				r.kind = KIND_TIMEOUT;
				return 1'b1;
			end
			return 1'b0;
		end
		case (fstate)
			FR_WAIT_CR: begin
				if (b == CH_CR) begin
					fstate = FR_WAIT_LF;
					idle_ticks = '0;
				end
				return 1'b0;
			end
			FR_WAIT_LF: begin
				if (b == CH_LF) begin
					restart_line();
					fstate = FR_PAYLOAD;
					idle_ticks = '0;
					return 1'b0;
				end
				if (b == CH_CR)
					return 1'b0;
				restart_line();
				r.kind = KIND_DISCARD;
				return 1'b1;
			end
			FR_PAYLOAD: begin
				if (b == CH_CR) begin
					fstate = FR_STOP_LF;
					idle_ticks = '0;
					return 1'b0;
				end
				if (line_len >= cap_limit) begin
					restart_line();
					r.kind = KIND_DISCARD;
					return 1'b1;
				end
				if (line_len >= OK_LEN)
					ok_live = 1'b0;
				else if (b != OK_TEXT[line_len])
					ok_live = 1'b0;
				if (line_len >= ERR_LEN)
					err_live = 1'b0;
				else if (b != ERR_TEXT[line_len])
					err_live = 1'b0;
				if (line_len < CME_LEN) begin
					if (b != CME_TEXT[line_len])
						cme_live = 1'b0;
				end
				r.kind = KIND_BYTE;
				r.pbyte = b;
				r.idx = line_len;
				line_len++;
				idle_ticks = '0;
				return 1'b1;
			end
			default: begin
				if (b != CH_LF) begin
					restart_line();
					r.kind = KIND_DISCARD;
					return 1'b1;
				end
				idle_ticks = '0;
				r.kind = KIND_DONE;
				r.len = line_len;
				if (ok_live && line_len == OK_LEN)
					r.rtype = RESP_OK;
				else if (err_live && line_len == ERR_LEN)
					r.rtype = RESP_ERROR;
				else if (cme_live && line_len >= CME_LEN) begin
					r.rtype = RESP_ERROR;
					r.len = line_len - LEN_W'(CME_LEN);
					r.start = CME_START;
				end
				restart_line();
				return 1'b1;
			end
		endcase
	endfunction

	task automatic send_item(input op_t op, input logic [7:0] b, input bit typed,
			input bit has_res, input line_res_t res);
		int gap;
		int r;
		line_res_t got;
		bit any;
		gap = 0;
		if (!calm) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				gap = 0;
			else if (r < 90)
				gap = $urandom_range(1, 3);
			else if (r < 98)
				gap = $urandom_range(4, 10);
			else
				gap = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		phase_items++;
		any = frame_predict(op, b, got);
		if (typed) begin
			if (has_res)
				pending_results.push_back(res);
		end else if (any)
			pending_results.push_back(got);
	endtask

	task automatic feed_byte(input logic [7:0] b);
		send_item(OP_BYTE, b, 1'b0, 1'b0, NONE);
	endtask

	task automatic feed_tick();
		send_item(OP_TICK, 8'($urandom), 1'b0, 1'b0, NONE);
	endtask

	// lowers valid, drains all results, then lets the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input reg_idx_t idx, input logic [23:0] val);
		logic [CFG_W-1:0] want;
		want = (idx == REG_CAPACITY) ? CFG_W'(val[LEN_W-1:0]) : CFG_W'(val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= CFG_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_CAPACITY)
			cap_limit = val[LEN_W-1:0];
		else
			tmo_limit = val[TMR_W-1:0];
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			note_mismatch($sformatf("register %0d read %0h want %0h", idx, prdata, want));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [7:0] rand_payload_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == CH_CR && $urandom_range(0, 49) != 0)
			b = 8'h0C;
		return b;
	endfunction

	task automatic random_line();
		logic [7:0] pl[$];
		int pick;
		int n;
		int k;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			for (k = 0; k < OK_LEN; k++) pl.push_back(OK_TEXT[k]);
		end else if (pick < 28) begin
			for (k = 0; k < ERR_LEN; k++) pl.push_back(ERR_TEXT[k]);
		end else if (pick < 45) begin
			for (k = 0; k < CME_LEN; k++) pl.push_back(CME_TEXT[k]);
			n = $urandom_range(0, 6);
			repeat (n) pl.push_back(rand_payload_byte());
		end else if (pick < 60) begin
			// near miss of one of the fixed texts
			n = $urandom_range(0, 2);
			if (n == 0)
				for (k = 0; k < OK_LEN; k++) pl.push_back(OK_TEXT[k]);
			else if (n == 1)
				for (k = 0; k < ERR_LEN; k++) pl.push_back(ERR_TEXT[k]);
			else
				for (k = 0; k < CME_LEN; k++) pl.push_back(CME_TEXT[k]);
			case ($urandom_range(0, 2))
				0: begin
					k = $urandom_range(0, pl.size() - 1);
					pl[k] = pl[k] ^ 8'($urandom_range(1, 255));
					if (pl[k] == CH_CR)
						pl[k] = 8'h00;
				end
				1: void'(pl.pop_back());
				default: pl.push_back(rand_payload_byte());
			endcase
		end else begin
			if (cap_limit <= 64 && $urandom_range(0, 9) == 0)
				n = int'(cap_limit) - 1 + $urandom_range(0, 2);
			else
				n = $urandom_range(0, 12);
			repeat (n) pl.push_back(rand_payload_byte());
		end
		feed_byte(CH_CR);
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 2)) feed_byte(CH_CR);
		if ($urandom_range(0, 19) == 0)
			feed_byte(rand_payload_byte());
		feed_byte(CH_LF);
		foreach (pl[i]) begin
			if ($urandom_range(0, 19) == 0)
				feed_tick();
			feed_byte(pl[i]);
		end
		feed_byte(CH_CR);
		if ($urandom_range(0, 9) == 0)
			feed_byte(rand_payload_byte());
		else
			feed_byte(CH_LF);
	endtask

	always @(posedge clk) begin
		if (calm)
			m_tready <= 1'b1;
		else if (rdy_hold != 0)
			rdy_hold <= rdy_hold - 1;
		else begin
			rdy_pick = $urandom_range(0, 99);
			if (rdy_pick < 60) begin
				m_tready <= 1'b1;
				rdy_hold <= $urandom_range(0, 8);
			end else if (rdy_pick < 95) begin
				m_tready <= 1'b0;
				rdy_hold <= $urandom_range(0, 3);
			end else begin
				m_tready <= 1'b0;
				rdy_hold <= $urandom_range(10, 40);
			end
		end
	end

	always @(posedge clk) begin : result_check
		line_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0)
				note_mismatch($sformatf("unexpected result kind %0d", m_tuser[1:0]));
			else begin
				want = pending_results.pop_front();
				if (m_tuser[1:0] !== want.kind)
					note_mismatch($sformatf("kind %0d want %0d", m_tuser[1:0], want.kind));
				if (m_tuser[3:2] !== want.rtype)
					note_mismatch($sformatf("response_type %0d want %0d",
						m_tuser[3:2], want.rtype));
				if (m_tdata[7:0] !== want.pbyte)
					note_mismatch($sformatf("payload_byte %0h want %0h",
						m_tdata[7:0], want.pbyte));
				if (m_tdata[17:8] !== want.idx)
					note_mismatch($sformatf("byte_index %0d want %0d",
						m_tdata[17:8], want.idx));
				if (m_tdata[27:18] !== want.len)
					note_mismatch($sformatf("response_length %0d want %0d",
						m_tdata[27:18], want.len));
				if (m_tdata[31:28] !== want.start)
					note_mismatch($sformatf("payload_start %0d want %0d",
						m_tdata[31:28], want.start));
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_BYTE;
		m_tready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cap_limit = CAP_RESET[LEN_W-1:0];
		tmo_limit = TMO_RESET[TMR_W-1:0];
		idle_ticks = '0;
		restart_line();
		phase_items = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].cfg) begin
				settle();
				write_register(DIRECTED[i].creg, DIRECTED[i].cval);
			end else
				send_item(DIRECTED[i].op, DIRECTED[i].data, DIRECTED[i].typed,
					DIRECTED[i].has_res, DIRECTED[i].res);
		end

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			write_register(REG_CAPACITY, 24'(PHASE_CAP[ph]));
			write_register(REG_TIMEOUT, PHASE_TMO[ph]);
			calm = (ph == 3);
			phase_items = 0;
			while (phase_items < 160) begin
				case ($urandom_range(0, 19))
					0, 1, 2: repeat ($urandom_range(1, 5)) begin
						if ($urandom_range(0, 3) == 0)
							feed_tick();
						else
							feed_byte(8'($urandom));
					end
					3, 4: begin
						if (tmo_limit <= 64)
							repeat (int'(tmo_limit) + $urandom_range(0, 3)) feed_tick();
						else
							repeat ($urandom_range(1, 4)) feed_tick();
					end
					default: random_line();
				endcase
			end
		end
		calm = 1'b0;

		settle();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("tb_at_response_line_framer_core passed");
		else
			$display("tb_at_response_line_framer_core failed");
		$finish;
	end

endmodule
